// ----- rtl/core/gftj_pkg.sv -----
// ============================================================================
// gftj_pkg
// Shared types and constants for the greedy full-text justifier: payload
// structs of both channels and the controller/datapath command and status.
// ============================================================================
package gftj_pkg;

    // Default sizing of the line buffer and width clamp
    localparam int GFTJ_MAX_WIDTH      = 64;
    localparam int GFTJ_MAX_LINE_WORDS = 32;

    // Field widths of the channels
    localparam int GFTJ_LEN_W  = 7;
    localparam int GFTJ_SLOT_W = 5;
    localparam int GFTJ_COL_W  = 6;

    // Line width after reset
    localparam logic [GFTJ_LEN_W-1:0] GFTJ_WIDTH_RESET = 7'd16;

    // Input transaction: one word
    typedef struct packed {
        logic [GFTJ_LEN_W-1:0] word_length;
        logic                  final_word;
    } gftj_word_t;

    // Output transaction: layout of one word
    typedef struct packed {
        logic [GFTJ_SLOT_W-1:0] word_slot;
        logic [GFTJ_COL_W-1:0]  start_column;
        logic [GFTJ_COL_W-1:0]  spaces_after;
        logic                   line_end;
        logic                   text_end;
        logic                   too_long;
    } gftj_layout_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming word
        logic load_err;    // put an error result in the output register
        logic start_line;  // begin emitting the open line
        logic start_last;  // the line being started is the final one
        logic load_word;   // put the current word's layout in the output register
        logic clear_line;  // empty the open line
        logic store;       // append the held word to the open line
    } gftj_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bad;         // held word is empty or longer than the width
        logic need_close;  // held word does not fit on the open line
        logic fin;         // held word is the last of the text
        logic count_zero;  // open line is empty
        logic multi;       // open line has more than one word
        logic div_done;    // gap quotient and remainder are ready
        logic out_free;    // output register can take a result
        logic last_word;   // emission index is at the line's last word
        logic final_line;  // line being emitted is the final one
    } gftj_status_t;

endpackage

// ----- rtl/core/gftj_div.sv -----
// ============================================================================
// gftj_div
// Restoring divider for the gap spacing: one quotient bit per cycle while
// busy; done rises once the last quotient bit is in and holds until start.
// ============================================================================
module gftj_div
    import gftj_pkg::*;
#(
    parameter int DIVIDEND_W = 8,
    parameter int DIVISOR_W  = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  take;
    logic [DIVISOR_W:0]    diff;
    logic [DIVIDEND_W-1:0] dvd_next;
    logic [DIVISOR_W-1:0]  rem_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        take     = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_next = take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        dvd_next = {dvd_reg[DIVIDEND_W-2:0], take};
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/gftj_dp.sv -----
// ============================================================================
// gftj_dp
// Justifier datapath: width register, held word, open-line buffer, gap
// divider, column accumulator and the output register.
// ============================================================================
module gftj_dp
    import gftj_pkg::*;
#(
    parameter int MAX_WIDTH      = GFTJ_MAX_WIDTH,
    parameter int MAX_LINE_WORDS = GFTJ_MAX_LINE_WORDS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  line_width_we,
    input  logic [GFTJ_LEN_W-1:0] line_width_wdata,
    input  gftj_word_t            word,
    output gftj_layout_t          layout,
    output logic                  layout_valid,
    input  logic                  layout_ready,
    input  gftj_cmd_t             cmd,
    output gftj_status_t          status
);

    localparam int XW = $clog2(MAX_WIDTH + MAX_LINE_WORDS + 128);
    localparam int TW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_LINE_WORDS + 1);
    localparam int AW = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;

    logic [GFTJ_LEN_W-1:0] line_width_reg;
    logic [GFTJ_LEN_W-1:0] len_reg;
    logic                  fin_reg;
    logic [CW-1:0]         count_reg;
    logic [TW-1:0]         total_reg;
    logic [AW-1:0]         idx_reg;
    logic [XW-1:0]         col_reg;
    logic                  justify_reg;
    logic                  final_reg;
    logic                  out_valid_reg;
    gftj_layout_t          out_reg;

    logic [GFTJ_LEN_W-1:0] mem [MAX_LINE_WORDS];
    logic [GFTJ_LEN_W-1:0] rd_data_reg;

    logic [XW-1:0] w_x;
    logic [XW-1:0] len_x;
    logic [XW-1:0] tot_x;
    logic [XW-1:0] gaps_x;
    logic [XW-1:0] room_x;
    logic [XW-1:0] extra_x;
    logic [XW-1:0] word_x;
    logic [XW-1:0] end_x;
    logic [XW-1:0] gap_sp_x;
    logic [XW-1:0] pad_sp_x;
    logic [XW-1:0] sp_x;
    logic          bad;
    logic          need_close;
    logic          multi;
    logic          last_word;
    logic          out_free;
    logic          div_start;
    logic          div_done;
    logic [XW-1:0] div_q;
    logic [CW-1:0] div_r;

    // Clamp the width register and test the held word against the open line
    always_comb
    begin
        if (line_width_reg == '0)
            w_x = XW'(1);
        else if (XW'(line_width_reg) > XW'(MAX_WIDTH))
            w_x = XW'(MAX_WIDTH);
        else
            w_x = XW'(line_width_reg);
        len_x      = XW'(len_reg);
        tot_x      = XW'(total_reg);
        bad        = (len_reg == '0) || (len_x > w_x);
        need_close = (count_reg != '0) &&
                     ((tot_x + XW'(count_reg) + len_x > w_x) ||
                      (count_reg >= CW'(MAX_LINE_WORDS)));
        multi      = (count_reg > CW'(1));
        gaps_x     = XW'(count_reg) - XW'(1);
        room_x     = (w_x > tot_x) ? (w_x - tot_x) : '0;
        extra_x    = (room_x < gaps_x) ? gaps_x : room_x;
    end

    // Work out the current word's column and the spaces after it
    always_comb
    begin
        word_x    = XW'(rd_data_reg);
        end_x     = col_reg + word_x;
        last_word = ((CW'(idx_reg) + CW'(1)) == count_reg);
        gap_sp_x  = justify_reg ? (div_q + XW'(CW'(idx_reg) < div_r)) : XW'(1);
        pad_sp_x  = (w_x > end_x) ? (w_x - end_x) : '0;
        sp_x      = last_word ? pad_sp_x : gap_sp_x;
    end

    assign out_free  = !out_valid_reg || layout_ready;
    assign div_start = cmd.start_line && !cmd.start_last && multi;

    gftj_div #(
        .DIVIDEND_W (XW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (extra_x),
        .divisor   (count_reg - CW'(1)),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Write the width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_width_reg <= GFTJ_WIDTH_RESET;
        else if (line_width_we)
            line_width_reg <= line_width_wdata;
    end

    // Track the open line and the emission position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            justify_reg <= 1'b0;
            final_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_line)
            begin
                count_reg <= '0;
                total_reg <= '0;
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + CW'(1);
                total_reg <= total_reg + TW'(len_reg);
            end
            if (cmd.start_line)
            begin
                idx_reg     <= '0;
                justify_reg <= !cmd.start_last && multi;
                final_reg   <= cmd.start_last;
            end
            else if (cmd.load_word)
                idx_reg <= idx_reg + AW'(1);
        end
    end

    // Hold the word, the running column and the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg <= word.word_length;
            fin_reg <= word.final_word;
        end
        if (cmd.start_line)
            col_reg <= '0;
        else if (cmd.load_word)
            col_reg <= end_x + sp_x;
        if (cmd.load_err)
        begin
            out_reg.word_slot    <= '0;
            out_reg.start_column <= '0;
            out_reg.spaces_after <= '0;
            out_reg.line_end     <= 1'b0;
            out_reg.text_end     <= fin_reg && (count_reg == '0);
            out_reg.too_long     <= 1'b1;
        end
        else if (cmd.load_word)
        begin
            out_reg.word_slot    <= GFTJ_SLOT_W'(idx_reg);
            out_reg.start_column <= GFTJ_COL_W'(col_reg);
            out_reg.spaces_after <= GFTJ_COL_W'(sp_x);
            out_reg.line_end     <= last_word;
            out_reg.text_end     <= last_word && final_reg;
            out_reg.too_long     <= 1'b0;
        end
    end

    // Line buffer: write on store, registered read at the emission index
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[count_reg[AW-1:0]] <= len_reg;
        rd_data_reg <= mem[idx_reg];
    end

    // Raise valid on load, drop it when the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_err || cmd.load_word)
            out_valid_reg <= 1'b1;
        else if (layout_ready)
            out_valid_reg <= 1'b0;
    end

    assign layout       = out_reg;
    assign layout_valid = out_valid_reg;

    always_comb
    begin
        status            = '0;
        status.bad        = bad;
        status.need_close = need_close;
        status.fin        = fin_reg;
        status.count_zero = (count_reg == '0);
        status.multi      = multi;
        status.div_done   = div_done;
        status.out_free   = out_free;
        status.last_word  = last_word;
        status.final_line = final_reg;
    end

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (count_reg < CW'(MAX_LINE_WORDS)))
        else $error("word stored into a full line");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_word |-> (count_reg != '0))
        else $error("layout emitted from an empty line");

    a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_word && justify_reg) |-> div_done)
        else $error("justified gap used before the divider finished");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_line |=> (count_reg == '0) && (total_reg == '0))
        else $error("line not cleared after its last word");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(MAX_WIDTH))
        else $error("line letter total beyond the width limit");

endmodule

// ----- rtl/core/gftj_ctrl.sv -----
// ============================================================================
// gftj_ctrl
// Justifier controller: sequences word intake, error results, line closing,
// gap division and the per-word layout emission.
// ============================================================================
module gftj_ctrl
    import gftj_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         word_valid,
    output logic         word_ready,
    input  gftj_status_t status,
    output gftj_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_ERR      = 7'b0000100,
        S_DIV      = 7'b0001000,
        S_EMIT_RD  = 7'b0010000,
        S_EMIT_OUT = 7'b0100000,
        S_STORE    = 7'b1000000
    } gftj_state_t;

    gftj_state_t state_reg;
    gftj_state_t state_next;

    // Decide the next step and the datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        word_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                word_ready = 1'b1;
                if (word_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.bad)
                    state_next = S_ERR;
                else if (status.need_close)
                begin
                    cmd.start_line = 1'b1;
                    state_next     = status.multi ? S_DIV : S_EMIT_RD;
                end
                else
                    state_next = S_STORE;
            end
            S_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.load_err = 1'b1;
                    if (status.fin && !status.count_zero)
                    begin
                        cmd.start_line = 1'b1;
                        cmd.start_last = 1'b1;
                        state_next     = S_EMIT_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_word = 1'b1;
                    if (status.last_word)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = status.final_line ? S_IDLE : S_STORE;
                    end
                    else
                        state_next = S_EMIT_RD;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (status.fin)
                begin
                    cmd.start_line = 1'b1;
                    cmd.start_last = 1'b1;
                    state_next     = S_EMIT_RD;
                end
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_line || cmd.load_word || cmd.store) |-> !word_ready)
        else $error("new word offered while a line is being processed");

    a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_err && cmd.load_word))
        else $error("two results loaded in one cycle");

endmodule

// ----- rtl/core/greedy_full_text_justifier_unit.sv -----
// ============================================================================
// greedy_full_text_justifier_unit
// A word that fits passes through intake, check and store, with no result;
// closing a line of several words first runs the gap division, then each
// word of the line is read from the buffer and loaded for output in turn.
// One word at a time: the next word is taken only once the last one and any
// line it closed are done; a stalled layout channel holds the emission.
// Reset: rst_n clears the open line and the controller; line_width returns
// to 16. The line buffer is not cleared.
// ============================================================================
module greedy_full_text_justifier_unit
    import gftj_pkg::*;
#(
    parameter int MAX_WIDTH      = GFTJ_MAX_WIDTH,
    parameter int MAX_LINE_WORDS = GFTJ_MAX_LINE_WORDS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  line_width_we,
    input  logic [GFTJ_LEN_W-1:0] line_width_wdata,
    input  logic                  word_valid,
    output logic                  word_ready,
    input  gftj_word_t            word,
    output logic                  layout_valid,
    input  logic                  layout_ready,
    output gftj_layout_t          layout
);

    gftj_cmd_t    cmd;
    gftj_status_t status;

    gftj_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .status     (status),
        .cmd        (cmd)
    );

    gftj_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_LINE_WORDS (MAX_LINE_WORDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .line_width_we    (line_width_we),
        .line_width_wdata (line_width_wdata),
        .word             (word),
        .layout           (layout),
        .layout_valid     (layout_valid),
        .layout_ready     (layout_ready),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for greedy_full_text_justifier_unit
// Streams word lengths into the justifier and checks the layout transactions
// against a line-filling predictor kept in the testbench. The line width is
// moved through typical, extreme and out-of-range settings while the block
// is idle, including changes with a line still open. Both handshakes see
// random stall bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gftj_pkg::*;

    localparam int WIDTH_CAP     = GFTJ_MAX_WIDTH;
    localparam int MAX_WORDS     = GFTJ_MAX_LINE_WORDS;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 42;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  line_width_we = 1'b0;
    logic [GFTJ_LEN_W-1:0] line_width_wdata = '0;
    logic                  word_valid = 1'b0;
    logic                  word_ready;
    gftj_word_t            word = '0;
    logic                  layout_valid;
    logic                  layout_ready = 1'b0;
    gftj_layout_t          layout;

    // Stimulus and expectation stores
    gftj_word_t   words_to_send [$];
    gftj_layout_t layout_due [$];

    // Predictor state: width register and the open line
    logic [GFTJ_LEN_W-1:0] width_reg = GFTJ_WIDTH_RESET;
    int                    open_len [MAX_WORDS];
    int                    open_count = 0;
    int                    open_letters = 0;

    // Handshake bookkeeping
    logic word_accepted = 1'b0;
    bit   idling = 1'b1;
    int   send_gap = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    // Run statistics
    int mismatches = 0;
    int words_taken = 0;
    int results_checked = 0;
    int lines_seen = 0;
    int rejects_seen = 0;
    int width_settings = 0;

    greedy_full_text_justifier_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .line_width_we    (line_width_we),
        .line_width_wdata (line_width_wdata),
        .word_valid       (word_valid),
        .word_ready       (word_ready),
        .word             (word),
        .layout_valid     (layout_valid),
        .layout_ready     (layout_ready),
        .layout           (layout)
    );

    // Generate a 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Clamp the width register to the usable range
    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > WIDTH_CAP)
            w = WIDTH_CAP;
        return w;
    endfunction

    task automatic add_layout(int slot, int col, int sp, bit line_last, bit too_long);
        gftj_layout_t r;
        r.word_slot    = slot[GFTJ_SLOT_W-1:0];
        r.start_column = col[GFTJ_COL_W-1:0];
        r.spaces_after = sp[GFTJ_COL_W-1:0];
        r.line_end     = line_last;
        r.text_end     = 1'b0;
        r.too_long     = too_long;
        layout_due = {layout_due, r};
    endtask

    // Lay out the open line, fully justified unless it is the last one
    task automatic close_line(int w, bit last_line);
        int n;
        int gaps;
        int spare;
        int q;
        int r;
        int col;
        int sp;
        int line_end_col;
        n = open_count;
        q = 1;
        r = 0;
        col = 0;
        if (n > 0)
        begin
            if (!last_line && n > 1)
            begin
                gaps  = n - 1;
                spare = (w > open_letters) ? w - open_letters : 0;
                if (spare < gaps)
                    spare = gaps;
                q = spare / gaps;
                r = spare % gaps;
            end
            for (int i = 0; i < n; i++)
            begin
                if (i + 1 < n)
                    sp = q + ((i < r) ? 1 : 0);
                else
                begin
                    line_end_col = col + open_len[i];
                    sp = (w > line_end_col) ? w - line_end_col : 0;
                end
                add_layout(i, col, sp, i + 1 == n, 1'b0);
                col += open_len[i] + sp;
            end
        end
        open_count   = 0;
        open_letters = 0;
    endtask

    // Predict the layout transactions caused by one accepted word
    task automatic justify_word(gftj_word_t item);
        int w;
        int len;
        int due_before;
        w = eff_width();
        len = int'(item.word_length);
        due_before = layout_due.size();
        if (len == 0 || len > w)
            add_layout(0, 0, 0, 1'b0, 1'b1);
        else
        begin
            if (open_count > 0 &&
                (open_letters + open_count + len > w || open_count >= MAX_WORDS))
                close_line(w, 1'b0);
            open_len[open_count] = len;
            open_count++;
            open_letters += len;
        end
        if (item.final_word)
        begin
            close_line(w, 1'b1);
            if (layout_due.size() > due_before)
                layout_due[layout_due.size() - 1].text_end = 1'b1;
        end
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Match one layout transaction against the oldest expectation
    task automatic check_layout(gftj_layout_t got);
        gftj_layout_t want;
        if (layout_due.size() == 0)
        begin
            $display("%0t: unexpected layout, expected none, actual %h", $time, got);
            mismatches++;
        end
        else
        begin
            want = layout_due.pop_front();
            compare_field("word_slot", 8'(want.word_slot), 8'(got.word_slot));
            compare_field("start_column", 8'(want.start_column), 8'(got.start_column));
            compare_field("spaces_after", 8'(want.spaces_after), 8'(got.spaces_after));
            compare_field("line_end", 8'(want.line_end), 8'(got.line_end));
            compare_field("text_end", 8'(want.text_end), 8'(got.text_end));
            compare_field("too_long", 8'(want.too_long), 8'(got.too_long));
            results_checked++;
            if (want.line_end)
                lines_seen++;
            if (want.too_long)
                rejects_seen++;
        end
    endtask

    // Monitor: check results first, then predict from the accepted word
    always @(posedge clk)
    begin
        if (!rst_n)
            word_accepted <= 1'b0;
        else
        begin
            word_accepted <= word_valid && word_ready;
            if (layout_valid && layout_ready)
                check_layout(layout);
            if (word_valid && word_ready)
            begin
                justify_word(word);
                words_taken++;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (word_valid && word_ready) || (layout_valid && layout_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, layout_due.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Driver: present queued words, with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
            word_valid <= 1'b0;
        else if (!(word_valid && !word_accepted))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                word_valid <= 1'b0;
            end
            else if (words_to_send.size() > 0)
            begin
                word <= words_to_send.pop_front();
                word_valid <= 1'b1;
                if (idling && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 5);
            end
            else
                word_valid <= 1'b0;
        end
    end

    // Receiver: stall the layout channel in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            layout_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            layout_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            layout_ready <= 1'b0;
        end
        else
            layout_ready <= 1'b1;
    end

    task automatic queue_word(int len, bit fin);
        gftj_word_t item;
        item.word_length = len[GFTJ_LEN_W-1:0];
        item.final_word  = fin;
        words_to_send = {words_to_send, item};
    endtask

    // Hold until every word is sent and every result has come back
    task automatic wait_until_idle();
        while (words_to_send.size() != 0 || word_valid || layout_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_width(int value);
        wait_until_idle();
        line_width_we    <= 1'b1;
        line_width_wdata <= value[GFTJ_LEN_W-1:0];
        @(negedge clk);
        line_width_we <= 1'b0;
        width_reg = value[GFTJ_LEN_W-1:0];
        width_settings++;
    endtask

    // Mostly short words that pack several to a line, some full-width words,
    // and a few empty or oversized ones
    function automatic int pick_length(int w);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return 0;
        if (roll < 8)
            return $urandom_range(127, w + 1);
        if (roll < 15)
            return w;
        if (roll < 65)
            return $urandom_range(1, (w + 3) / 4);
        return $urandom_range(1, w);
    endfunction

    task automatic queue_text(int count);
        int w;
        w = eff_width();
        for (int i = 0; i < count; i++)
            queue_word(pick_length(w), $urandom_range(0, 11) == 0);
    endtask

    initial
    begin
        int widths [10];
        widths = '{16, 7, 64, 1, 0, 127, 40, 65, 0, 12};
        widths[8] = $urandom_range(2, 63);

        // Reset
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset width of 16
        queue_word(16, 1'b0);   // fill a line exactly
        queue_word(1, 1'b0);    // close a single-word line
        queue_word(0, 1'b0);    // empty word
        queue_word(17, 1'b0);   // one over the width
        queue_word(127, 1'b0);  // largest length
        queue_word(3, 1'b0);
        queue_word(4, 1'b0);
        queue_word(2, 1'b0);
        queue_word(7, 1'b0);    // close a line with even gaps
        queue_word(5, 1'b0);
        queue_word(2, 1'b1);    // final line, left-justified
        queue_word(0, 1'b1);    // rejected final word on an empty line
        queue_word(5, 1'b0);
        queue_word(20, 1'b1);   // rejected final word ahead of the last line
        queue_word(16, 1'b1);   // single full-width final word

        // Narrowest width
        set_width(1);
        queue_word(1, 1'b0);
        queue_word(1, 1'b0);
        queue_word(2, 1'b1);

        // Widest width, then shrink it with a line still open
        set_width(WIDTH_CAP);
        queue_word(64, 1'b0);
        queue_word(1, 1'b0);
        queue_word(30, 1'b0);
        queue_word(30, 1'b0);
        set_width(10);
        queue_word(5, 1'b1);

        // Out-of-range settings clamp to the limits
        set_width(0);
        queue_word(1, 1'b0);
        queue_word(1, 1'b1);
        set_width(127);
        queue_word(64, 1'b1);

        // Overrun the per-line word limit with one-letter words
        set_width(WIDTH_CAP);
        for (int i = 0; i < 39; i++)
            queue_word(1, 1'b0);
        queue_word(1, 1'b1);

        // Random text across a range of widths; every third phase and the last run without stalls
        for (int p = 0; p < 10; p++)
        begin
            set_width(widths[p]);
            idling = (p % 3 != 2) && (p != 9);
            queue_text(PHASE_WORDS);
        end

        // Drain and report
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d words over %0d width settings: %0d layouts checked,",
                 words_taken, width_settings, results_checked);
        $display("%0d lines closed, %0d words rejected, %0d mismatches",
                 lines_seen, rejects_seen, mismatches);
        if (mismatches == 0 && layout_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
